>>> hw/rtl/opu_pkg.sv
// Package for the optimizer parameter update block.
// Holds sizes, register and mode codes, reset values and the controller state type.
// No dependencies.
package opu_pkg;

  // element store
  localparam int DEPTH = 1024;
  localparam int IDX_W = $clog2(DEPTH);

  // fixed point
  localparam logic [24:0] ONE_Q24 = 25'h100_0000;

  // update rules (mode 3 acts as SGD)
  localparam logic [1:0] MODE_SGD  = 2'd0;
  localparam logic [1:0] MODE_ADAM = 2'd1;
  localparam logic [1:0] MODE_RMS  = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EPS   = 3'd4;

  // item actions
  localparam logic ACT_CLEAR = 1'b1;

  // register reset values
  localparam logic [1:0]  RST_MODE  = MODE_ADAM;
  localparam logic [23:0] RST_LR    = 24'd16777;
  localparam logic [23:0] RST_BETA1 = 24'd15099494;
  localparam logic [23:0] RST_BETA2 = 24'd16760438;
  localparam logic [23:0] RST_EPS   = 24'd1;

  // iterative units
  localparam int DIV_STEPS  = 64;
  localparam int SQRT_STEPS = 32;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLEAR,
    S_BP1,
    S_BP2,
    S_CR_SQ,
    S_CR_SQW,
    S_CR_DIV,
    S_CR_DIVW,
    S_LOAD,
    S_M1,
    S_M2,
    S_M3,
    S_V1,
    S_V2,
    S_V3,
    S_V4,
    S_V5,
    S_VSQW,
    S_QD,
    S_QDW,
    S_G1,
    S_G2,
    S_FIN
  } state_t;

endpackage

>>> hw/rtl/optimizer_param_update.sv
// Optimizer parameter update (SGD, Adam, RMSprop) over a 1024-entry moment store.
// Depends on opu_pkg. Holds the controller, one shared multiplier, an iterative
// square root unit, an iterative divider and the two moment memories.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------------------
//  input    | start / busy            | in_action, in_param_index, in_param_value,
//           |                         | in_gradient, in_first_of_step
//  result   | out_strobe (one cycle)  | out_index_out, out_new_value, out_saturated
//  config   | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One item at a time; an Adam item that opens a step also computes the bias-corrected rate.
// The strobe follows in the cycle after the last busy one, and the next item can be taken
// in that cycle. RMSprop and Adam items wait on the 32-step square root and the 64-step
// divider. A clear item, and reset, run a clearing pass over all 1024 entries of the
// moment memories; busy stays high during it. Config transfers are taken in every cycle.
// The result receiver cannot stall: each result is shown for exactly one cycle.
module optimizer_param_update (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_action,
  input  logic [opu_pkg::IDX_W-1:0]            in_param_index,
  input  logic signed [31:0]                   in_param_value,
  input  logic signed [31:0]                   in_gradient,
  input  logic                                 in_first_of_step,
  output logic                                 out_strobe,
  output logic [opu_pkg::IDX_W-1:0]            out_index_out,
  output logic signed [31:0]                   out_new_value,
  output logic                                 out_saturated,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [opu_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [23:0]                          cfg_data
);

  opu_pkg::state_t state_r, state_nxt;

  // configuration
  logic [1:0]  mode_r;
  logic [23:0] lr_r, b1_r, b2_r, eps_r;

  // item
  logic [opu_pkg::IDX_W-1:0] idx_r;
  logic [31:0] pval_r;
  logic [31:0] gmag_r;
  logic        gneg_r;

  // step state
  logic [24:0] bp1_r, bp2_r;
  logic [31:0] cr_r;

  // datapath
  logic [63:0] mul_a, mul_b, mul_r;
  logic [57:0] acc_r;
  logic [31:0] mnew_r;
  logic [38:0] gsq_r;
  logic [65:0] vacc_r;
  logic [28:0] den_r;
  logic [32:0] q_r;
  logic        neg_r;
  logic        sat_r;
  logic [opu_pkg::IDX_W-1:0] clr_cnt_r;

  // memories
  logic [31:0] m_mem [opu_pkg::DEPTH];
  logic [31:0] v_mem [opu_pkg::DEPTH];
  logic [31:0] m_rd_r, v_rd_r;
  logic        mem_we_m, mem_we_v;
  logic [opu_pkg::IDX_W-1:0] wr_addr, rd_addr;
  logic [31:0] m_wdata, v_wdata;

  // square root unit
  logic [63:0] sq_x_r, sq_res_r, sq_bit_r, sq_opnd, sq_t;
  logic [4:0]  sq_cnt_r;
  logic        sq_busy_r, sq_start;

  // divider unit
  logic [63:0] dv_n_r;
  logic [28:0] dv_rem_r, dv_den_r, dv_den;
  logic [29:0] dv_sh;
  logic        dv_ge;
  logic [5:0]  dv_cnt_r;
  logic        dv_busy_r, dv_start;

  // combinational values
  logic        accept, cfg_we, is_adam;
  logic [24:0] omb1, omb_v, d_cr;
  logic [23:0] beta_v;
  logic [31:0] mmag, mnew_mag;
  logic [57:0] mterm, msum, msmag;
  logic [33:0] msh;
  logic [31:0] m_val;
  logic        m_sat;
  logic [65:0] vsum;
  logic [41:0] vsh;
  logic [31:0] v_new;
  logic        v_sat;
  logic [32:0] den_sum;
  logic        q_big;
  logic [34:0] pext, qext, diff;
  logic        fin_sat;
  logic [31:0] fin_val;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign accept    = start && !busy;
  assign is_adam   = (mode_r == opu_pkg::MODE_ADAM);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= opu_pkg::RST_MODE;
      lr_r   <= opu_pkg::RST_LR;
      b1_r   <= opu_pkg::RST_BETA1;
      b2_r   <= opu_pkg::RST_BETA2;
      eps_r  <= opu_pkg::RST_EPS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        opu_pkg::CFG_MODE:  mode_r <= cfg_data[1:0];
        opu_pkg::CFG_LR:    lr_r   <= cfg_data;
        opu_pkg::CFG_BETA1: b1_r   <= cfg_data;
        opu_pkg::CFG_BETA2: b2_r   <= cfg_data;
        opu_pkg::CFG_EPS:   eps_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // arithmetic helpers
  always_comb begin
    omb1     = opu_pkg::ONE_Q24 - {1'b0, b1_r};
    beta_v   = is_adam ? b2_r : b1_r;
    omb_v    = opu_pkg::ONE_Q24 - {1'b0, beta_v};
    d_cr     = opu_pkg::ONE_Q24 - bp1_r;
    mmag     = m_rd_r[31] ? (~m_rd_r + 32'd1) : m_rd_r;
    mnew_mag = mnew_r[31] ? (~mnew_r + 32'd1) : mnew_r;

    // first moment: sign-magnitude shift, then clamp
    mterm = {2'b0, mul_r[55:0]};
    msum  = acc_r + (gneg_r ? (58'd0 - mterm) : mterm);
    msmag = msum[57] ? (58'd0 - msum) : msum;
    msh   = msmag[57:24];
    if (!msum[57]) begin
      m_sat = (msh > 34'h0_7FFF_FFFF);
      m_val = m_sat ? 32'h7FFF_FFFF : msh[31:0];
    end else begin
      m_sat = (msh > 34'h0_8000_0000);
      m_val = m_sat ? 32'h8000_0000 : (~msh[31:0] + 32'd1);
    end

    // second moment: final partial product, shift, clamp
    vsum  = vacc_r + {2'b0, mul_r[39:0], 24'b0};
    vsh   = vsum[65:24];
    v_sat = |vsh[41:32];
    v_new = v_sat ? 32'hFFFF_FFFF : vsh[31:0];

    den_sum = {1'b0, sq_res_r[31:0]} + {9'b0, eps_r};
    q_big   = (|dv_n_r[63:33]) || (dv_n_r[32] && (|dv_n_r[31:0]));

    // result: parameter minus signed step, clamped
    pext    = {{3{pval_r[31]}}, pval_r};
    qext    = {2'b0, q_r};
    diff    = neg_r ? (pext + qext) : (pext - qext);
    fin_sat = !((diff[34:31] == 4'b0000) || (diff[34:31] == 4'b1111));
    fin_val = fin_sat ? (diff[34] ? 32'h8000_0000 : 32'h7FFF_FFFF) : diff[31:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      opu_pkg::S_IDLE: begin
        if (accept) begin
          if (in_action == opu_pkg::ACT_CLEAR) state_nxt = opu_pkg::S_CLEAR;
          else if (is_adam && in_first_of_step) state_nxt = opu_pkg::S_BP1;
          else state_nxt = opu_pkg::S_LOAD;
        end
      end
      opu_pkg::S_CLEAR: begin
        if (clr_cnt_r == opu_pkg::IDX_W'(opu_pkg::DEPTH - 1)) state_nxt = opu_pkg::S_IDLE;
      end
      opu_pkg::S_BP1:    state_nxt = opu_pkg::S_BP2;
      opu_pkg::S_BP2:    state_nxt = opu_pkg::S_CR_SQ;
      opu_pkg::S_CR_SQ:  state_nxt = opu_pkg::S_CR_SQW;
      opu_pkg::S_CR_SQW: begin
        if (!sq_busy_r) state_nxt = opu_pkg::S_CR_DIV;
      end
      opu_pkg::S_CR_DIV: begin
        state_nxt = (d_cr == 25'd0) ? opu_pkg::S_LOAD : opu_pkg::S_CR_DIVW;
      end
      opu_pkg::S_CR_DIVW: begin
        if (!dv_busy_r) state_nxt = opu_pkg::S_LOAD;
      end
      opu_pkg::S_LOAD: begin
        if (is_adam) state_nxt = opu_pkg::S_M1;
        else if (mode_r == opu_pkg::MODE_RMS) state_nxt = opu_pkg::S_V1;
        else state_nxt = opu_pkg::S_G1;
      end
      opu_pkg::S_M1:   state_nxt = opu_pkg::S_M2;
      opu_pkg::S_M2:   state_nxt = opu_pkg::S_M3;
      opu_pkg::S_M3:   state_nxt = opu_pkg::S_V1;
      opu_pkg::S_V1:   state_nxt = opu_pkg::S_V2;
      opu_pkg::S_V2:   state_nxt = opu_pkg::S_V3;
      opu_pkg::S_V3:   state_nxt = opu_pkg::S_V4;
      opu_pkg::S_V4:   state_nxt = opu_pkg::S_V5;
      opu_pkg::S_V5:   state_nxt = opu_pkg::S_VSQW;
      opu_pkg::S_VSQW: begin
        if (!sq_busy_r) state_nxt = opu_pkg::S_QD;
      end
      opu_pkg::S_QD:   state_nxt = opu_pkg::S_QDW;
      opu_pkg::S_QDW: begin
        if (!dv_busy_r) state_nxt = opu_pkg::S_FIN;
      end
      opu_pkg::S_G1:   state_nxt = opu_pkg::S_G2;
      opu_pkg::S_G2:   state_nxt = opu_pkg::S_FIN;
      opu_pkg::S_FIN:  state_nxt = opu_pkg::S_IDLE;
      default:         state_nxt = opu_pkg::S_IDLE;
    endcase
  end

  // controller outputs: operand selects, unit starts, memory writes
  always_comb begin
    busy     = 1'b1;
    mul_a    = 64'd0;
    mul_b    = 64'd0;
    sq_start = 1'b0;
    dv_start = 1'b0;
    mem_we_m = 1'b0;
    mem_we_v = 1'b0;
    unique case (state_r)
      opu_pkg::S_IDLE:   busy = 1'b0;
      opu_pkg::S_CLEAR: begin
        mem_we_m = 1'b1;
        mem_we_v = 1'b1;
      end
      opu_pkg::S_BP1: begin
        mul_a = {39'd0, bp1_r};
        mul_b = {40'd0, b1_r};
      end
      opu_pkg::S_BP2: begin
        mul_a = {39'd0, bp2_r};
        mul_b = {40'd0, b2_r};
      end
      opu_pkg::S_CR_SQ:  sq_start = 1'b1;
      opu_pkg::S_CR_SQW: begin
        mul_a = {40'd0, lr_r};
        mul_b = {32'd0, sq_res_r[31:0]};
      end
      opu_pkg::S_CR_DIV: dv_start = (d_cr != 25'd0);
      opu_pkg::S_M1: begin
        mul_a = {40'd0, b1_r};
        mul_b = {32'd0, mmag};
      end
      opu_pkg::S_M2: begin
        mul_a = {39'd0, omb1};
        mul_b = {32'd0, gmag_r};
      end
      opu_pkg::S_V1: begin
        mul_a = {32'd0, gmag_r};
        mul_b = {32'd0, gmag_r};
      end
      opu_pkg::S_V2: begin
        mul_a = {40'd0, beta_v};
        mul_b = {32'd0, v_rd_r};
      end
      opu_pkg::S_V3: begin
        mul_a = {39'd0, omb_v};
        mul_b = {40'd0, gsq_r[23:0]};
      end
      opu_pkg::S_V4: begin
        mul_a = {39'd0, omb_v};
        mul_b = {49'd0, gsq_r[38:24]};
      end
      opu_pkg::S_V5: begin
        mem_we_v = 1'b1;
        mem_we_m = is_adam;
        sq_start = 1'b1;
      end
      opu_pkg::S_VSQW: begin
        mul_a = is_adam ? {32'd0, cr_r} : {40'd0, lr_r};
        mul_b = is_adam ? {32'd0, mnew_mag} : {32'd0, gmag_r};
      end
      opu_pkg::S_QD:     dv_start = 1'b1;
      opu_pkg::S_G1: begin
        mul_a = {40'd0, lr_r};
        mul_b = {32'd0, gmag_r};
      end
      default: ;
    endcase
  end

  // memory address and data selects
  assign rd_addr = (state_r == opu_pkg::S_IDLE) ? in_param_index : idx_r;
  assign wr_addr = (state_r == opu_pkg::S_CLEAR) ? clr_cnt_r : idx_r;
  assign m_wdata = (state_r == opu_pkg::S_CLEAR) ? 32'd0 : mnew_r;
  assign v_wdata = (state_r == opu_pkg::S_CLEAR) ? 32'd0 : v_new;
  assign sq_opnd = (state_r == opu_pkg::S_CR_SQ) ?
                   {15'd0, opu_pkg::ONE_Q24 - mul_r[48:24], 24'd0} :
                   {8'd0, v_new, 24'd0};
  assign dv_den  = (state_r == opu_pkg::S_CR_DIV) ? {4'd0, d_cr} : den_r;

  // moment memories, registered read
  always_ff @(posedge clk) begin
    if (mem_we_m) m_mem[wr_addr] <= m_wdata;
    m_rd_r <= m_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (mem_we_v) v_mem[wr_addr] <= v_wdata;
    v_rd_r <= v_mem[rd_addr];
  end

  // shared multiplier, registered product
  always_ff @(posedge clk) begin
    mul_r <= 64'(mul_a[31:0] * mul_b[31:0]);
  end

  // square root: one result bit per cycle
  assign sq_t = sq_res_r + sq_bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_busy_r <= 1'b0;
      sq_cnt_r  <= 5'd0;
    end else if (sq_start) begin
      sq_busy_r <= 1'b1;
      sq_cnt_r  <= 5'd0;
      sq_x_r    <= sq_opnd;
      sq_res_r  <= 64'd0;
      sq_bit_r  <= 64'h4000_0000_0000_0000;
    end else if (sq_busy_r) begin
      if (sq_x_r >= sq_t) begin
        sq_x_r   <= sq_x_r - sq_t;
        sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
      end else begin
        sq_res_r <= sq_res_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
      sq_cnt_r <= sq_cnt_r + 5'd1;
      if (sq_cnt_r == 5'(opu_pkg::SQRT_STEPS - 1)) sq_busy_r <= 1'b0;
    end
  end

  // restoring divider: one quotient bit per cycle
  assign dv_sh = {dv_rem_r, dv_n_r[63]};
  assign dv_ge = (dv_sh >= {1'b0, dv_den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_busy_r <= 1'b0;
      dv_cnt_r  <= 6'd0;
    end else if (dv_start) begin
      dv_busy_r <= 1'b1;
      dv_cnt_r  <= 6'd0;
      dv_n_r    <= mul_r;
      dv_rem_r  <= 29'd0;
      dv_den_r  <= dv_den;
    end else if (dv_busy_r) begin
      dv_rem_r <= dv_ge ? 29'(dv_sh - {1'b0, dv_den_r}) : dv_sh[28:0];
      dv_n_r   <= {dv_n_r[62:0], dv_ge};
      dv_cnt_r <= dv_cnt_r + 6'd1;
      if (dv_cnt_r == 6'(opu_pkg::DIV_STEPS - 1)) dv_busy_r <= 1'b0;
    end
  end

  // controller state and clearing counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= opu_pkg::S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == opu_pkg::S_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // step state: beta powers and bias-corrected rate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp1_r <= opu_pkg::ONE_Q24;
      bp2_r <= opu_pkg::ONE_Q24;
      cr_r  <= 32'd0;
    end else begin
      case (state_r)
        opu_pkg::S_IDLE: begin
          if (accept && in_action == opu_pkg::ACT_CLEAR) begin
            bp1_r <= opu_pkg::ONE_Q24;
            bp2_r <= opu_pkg::ONE_Q24;
            cr_r  <= 32'd0;
          end
        end
        opu_pkg::S_BP2:   bp1_r <= mul_r[48:24];
        opu_pkg::S_CR_SQ: bp2_r <= mul_r[48:24];
        opu_pkg::S_CR_DIV: begin
          if (d_cr == 25'd0) cr_r <= 32'hFFFF_FFFF;
        end
        opu_pkg::S_CR_DIVW: begin
          if (!dv_busy_r) cr_r <= (|dv_n_r[63:32]) ? 32'hFFFF_FFFF : dv_n_r[31:0];
        end
        default: ;
      endcase
    end
  end

  // item datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      opu_pkg::S_IDLE: begin
        if (accept) begin
          idx_r  <= in_param_index;
          pval_r <= in_param_value;
          gneg_r <= in_gradient[31];
          gmag_r <= in_gradient[31] ? (~in_gradient + 32'd1) : in_gradient;
        end
      end
      opu_pkg::S_M2:   acc_r <= m_rd_r[31] ? (58'd0 - mterm) : mterm;
      opu_pkg::S_M3:   mnew_r <= m_val;
      opu_pkg::S_V2:   gsq_r <= mul_r[62:24];
      opu_pkg::S_V3:   vacc_r <= {2'd0, mul_r};
      opu_pkg::S_V4:   vacc_r <= vacc_r + {2'd0, mul_r};
      opu_pkg::S_VSQW: begin
        if (!sq_busy_r) den_r <= (den_sum == 33'd0) ? 29'd1 : den_sum[28:0];
      end
      opu_pkg::S_QDW: begin
        if (!dv_busy_r) begin
          q_r   <= q_big ? 33'h1_0000_0000 : dv_n_r[32:0];
          neg_r <= is_adam ? mnew_r[31] : gneg_r;
        end
      end
      opu_pkg::S_G2: begin
        q_r   <= {2'd0, mul_r[54:24]};
        neg_r <= gneg_r;
      end
      default: ;
    endcase
  end

  // saturation flag for the item in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r <= 1'b0;
    end else begin
      case (state_r)
        opu_pkg::S_IDLE:    if (accept) sat_r <= 1'b0;
        opu_pkg::S_CR_DIV:  if (d_cr == 25'd0) sat_r <= 1'b1;
        opu_pkg::S_CR_DIVW: if (!dv_busy_r && (|dv_n_r[63:32])) sat_r <= 1'b1;
        opu_pkg::S_M3:      if (m_sat) sat_r <= 1'b1;
        opu_pkg::S_V5:      if (v_sat) sat_r <= 1'b1;
        opu_pkg::S_QDW:     if (!dv_busy_r && q_big) sat_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= (state_r == opu_pkg::S_FIN);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == opu_pkg::S_FIN) begin
      out_index_out <= idx_r;
      out_new_value <= fin_val;
      out_saturated <= sat_r || fin_sat;
    end
  end

endmodule

>>> hw/rtl/opu_checker.sv
// Port-level checker for optimizer_param_update, with its bind statement.
// Sees only the top-level handshake ports; no package dependency.
module opu_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe
);

  // an accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // a result only follows work in progress
  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(busy) && !busy))
    else $error("result strobe without preceding work");

  // one strobe per item
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held longer than one cycle");

  // reset starts the clearing pass
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (busy && !out_strobe))
    else $error("no clearing pass after reset");

endmodule

bind optimizer_param_update opu_checker u_opu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe)
);
